/* hdl/pwsc_pkg.sv */
// ----------------------------------------------------------------------------
// pwsc_pkg
// Shared widths, register indexes and pipeline payload types of the
// perspective warp source coordinate generator.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  localparam int unsigned DEST_W    = 15;
  localparam int unsigned UNIT_W    = 21;
  localparam int unsigned UNIT_FRAC = 20;
  localparam int unsigned VEC_W     = 63;
  localparam int unsigned ORG_W     = 48;
  localparam int unsigned H_W       = 48;
  localparam int unsigned PP_W      = 31;
  localparam int unsigned PPV_W     = 62;
  localparam int unsigned SIZE_W    = 32;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned CFG_AW    = 3;
  localparam int unsigned CFG_DW    = 63;

  // Plane term x*u + y*u with 20 fraction bits.
  localparam int unsigned PLANE_W   = DEST_W + UNIT_W + 2;
  // Plane point, divisor, magnitudes.
  localparam int unsigned R_W       = 50;
  localparam int unsigned D_W       = 51;
  localparam int unsigned DM_W      = 50;
  localparam int unsigned RM_W      = 48;
  localparam int unsigned HALF_W    = 24;
  localparam int unsigned PROD_W    = 2 * HALF_W;
  localparam int unsigned NUM_W     = H_W + RM_W;
  // Quotient bits kept by the divider; larger quotients saturate.
  localparam int unsigned Q_W       = 63;
  localparam int unsigned R0_W      = NUM_W - Q_W;
  localparam int unsigned S_W       = 64;

  localparam logic [Q_W-1:0] Q_LIMIT = {1'b1, {(Q_W-1){1'b0}}};

  typedef enum logic [CFG_AW-1:0] {
    REG_UNIT_X,
    REG_UNIT_Y,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_HEIGHT,
    REG_PP,
    REG_SIZE
  } reg_idx_e;

  typedef struct packed {
    logic [RM_W-1:0] rm_x;
    logic [RM_W-1:0] rm_y;
    logic            neg_x;
    logic            neg_y;
    logic [DM_W-1:0] dm;
    logic            dz;
  } proj_t;

  typedef struct packed {
    logic [DM_W-1:0] rem;
    logic [Q_W-1:0]  num;
    logic            ovf;
    logic            neg;
  } div_chan_t;

  typedef struct packed {
    div_chan_t       x;
    div_chan_t       y;
    logic [DM_W-1:0] dm;
    logic            dz;
  } div_t;

  typedef struct packed {
    logic [PIX_W-1:0] src_x;
    logic [PIX_W-1:0] src_y;
    logic             in_range;
  } res_t;

endpackage

/* hdl/pwsc_plane.sv */
// ----------------------------------------------------------------------------
// pwsc_plane
// Forms the plane point and the projection divisor in three stages.
// ----------------------------------------------------------------------------
module pwsc_plane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [pwsc_pkg::DEST_W-1:0]         dest_x_i,
  input  logic [pwsc_pkg::DEST_W-1:0]         dest_y_i,
  input  logic [pwsc_pkg::VEC_W-1:0]          unit_x_i,
  input  logic [pwsc_pkg::VEC_W-1:0]          unit_y_i,
  input  logic signed [pwsc_pkg::ORG_W-1:0]   origin_x_i,
  input  logic signed [pwsc_pkg::ORG_W-1:0]   origin_y_i,
  input  logic signed [pwsc_pkg::ORG_W-1:0]   origin_z_i,
  input  logic [pwsc_pkg::H_W-1:0]            height_i,
  output logic                                valid_o,
  output pwsc_pkg::proj_t                     proj_o
);

  localparam int unsigned PRD_W = pwsc_pkg::DEST_W + pwsc_pkg::UNIT_W + 1;

  logic signed [pwsc_pkg::PLANE_W-1:0] p_d [3];
  logic signed [pwsc_pkg::PLANE_W-1:0] p_q [3];
  logic signed [pwsc_pkg::R_W-1:0]     r_d [3];
  logic signed [pwsc_pkg::R_W-1:0]     r_q [3];
  logic signed [pwsc_pkg::ORG_W-1:0]   org [3];
  logic signed [pwsc_pkg::D_W-1:0]     d;
  pwsc_pkg::proj_t                     proj_d;
  pwsc_pkg::proj_t                     proj_q;
  logic                                v1_q, v2_q, v3_q;

  assign org[0] = origin_x_i;
  assign org[1] = origin_y_i;
  assign org[2] = origin_z_i;

  // Stage 1: dest * unit vectors, 20 fraction bits.
  always_comb begin
    logic signed [pwsc_pkg::UNIT_W-1:0] ux, uy;
    logic signed [PRD_W-1:0]            px, py;
    for (int k = 0; k < 3; k++) begin
      ux     = unit_x_i[k*pwsc_pkg::UNIT_W +: pwsc_pkg::UNIT_W];
      uy     = unit_y_i[k*pwsc_pkg::UNIT_W +: pwsc_pkg::UNIT_W];
      px     = $signed({1'b0, dest_x_i}) * ux;
      py     = $signed({1'b0, dest_y_i}) * uy;
      p_d[k] = pwsc_pkg::PLANE_W'(px) + pwsc_pkg::PLANE_W'(py);
    end
  end

  // Stage 2: bring the plane term to FRAC_BITS and add the origin.
  if (FRAC_BITS < pwsc_pkg::UNIT_FRAC) begin : g_round
    localparam int unsigned SH = pwsc_pkg::UNIT_FRAC - FRAC_BITS;
    always_comb begin
      logic                             neg;
      logic [pwsc_pkg::PLANE_W-1:0]     mag, rnd;
      logic signed [pwsc_pkg::R_W-1:0]  pf;
      for (int k = 0; k < 3; k++) begin
        neg    = p_q[k][pwsc_pkg::PLANE_W-1];
        mag    = neg ? -p_q[k] : p_q[k];
        rnd    = (mag + (pwsc_pkg::PLANE_W'(1) << (SH - 1))) >> SH;
        pf     = neg ? -$signed(pwsc_pkg::R_W'(rnd)) : $signed(pwsc_pkg::R_W'(rnd));
        r_d[k] = pf + pwsc_pkg::R_W'(org[k]);
      end
    end
  end else begin : g_shift
    localparam int unsigned SH = FRAC_BITS - pwsc_pkg::UNIT_FRAC;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        r_d[k] = (pwsc_pkg::R_W'(p_q[k]) <<< SH) + pwsc_pkg::R_W'(org[k]);
      end
    end
  end

  // Stage 3: divisor h - r.z and the magnitudes the divider works on.
  always_comb begin
    d             = $signed(pwsc_pkg::D_W'(height_i)) - pwsc_pkg::D_W'(r_q[2]);
    proj_d.rm_x   = pwsc_pkg::RM_W'(r_q[0][pwsc_pkg::R_W-1] ? -r_q[0] : r_q[0]);
    proj_d.rm_y   = pwsc_pkg::RM_W'(r_q[1][pwsc_pkg::R_W-1] ? -r_q[1] : r_q[1]);
    proj_d.neg_x  = r_q[0][pwsc_pkg::R_W-1] ^ d[pwsc_pkg::D_W-1];
    proj_d.neg_y  = r_q[1][pwsc_pkg::R_W-1] ^ d[pwsc_pkg::D_W-1];
    proj_d.dm     = pwsc_pkg::DM_W'(d[pwsc_pkg::D_W-1] ? -d : d);
    proj_d.dz     = (d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q    <= p_d;
      r_q    <= r_d;
      proj_q <= proj_d;
    end
  end

  assign valid_o = v3_q;
  assign proj_o  = proj_q;

endmodule

/* hdl/pwsc_mul.sv */
// ----------------------------------------------------------------------------
// pwsc_mul
// Forms the 96-bit dividend h * |r| from products of 24-bit halves and
// prepares the first divider remainder and the overflow flag.
// ----------------------------------------------------------------------------
module pwsc_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  pwsc_pkg::proj_t            proj_i,
  input  logic [pwsc_pkg::H_W-1:0]   height_i,
  output logic                       valid_o,
  output pwsc_pkg::div_t             div_o
);

  logic [pwsc_pkg::PROD_W-1:0] pp_d [2][4];
  logic [pwsc_pkg::PROD_W-1:0] pp_q [2][4];
  logic [pwsc_pkg::NUM_W-1:0]  n_d  [2];
  logic [pwsc_pkg::NUM_W-1:0]  n_q  [2];
  pwsc_pkg::proj_t             pa_q, pb_q;
  pwsc_pkg::div_t              div_d, div_q;
  logic                        va_q, vb_q, vc_q;

  // Stage A: four partial products per channel.
  always_comb begin
    logic [pwsc_pkg::HALF_W-1:0] hh, hl, rh, rl;
    hh = height_i[pwsc_pkg::H_W-1 -: pwsc_pkg::HALF_W];
    hl = height_i[pwsc_pkg::HALF_W-1:0];
    for (int c = 0; c < 2; c++) begin
      rh = (c == 0) ? proj_i.rm_x[pwsc_pkg::RM_W-1 -: pwsc_pkg::HALF_W]
                    : proj_i.rm_y[pwsc_pkg::RM_W-1 -: pwsc_pkg::HALF_W];
      rl = (c == 0) ? proj_i.rm_x[pwsc_pkg::HALF_W-1:0]
                    : proj_i.rm_y[pwsc_pkg::HALF_W-1:0];
      pp_d[c][0] = hl * rl;
      pp_d[c][1] = hl * rh;
      pp_d[c][2] = hh * rl;
      pp_d[c][3] = hh * rh;
    end
  end

  // Stage B: sum of the partial products.
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      n_d[c] = (pwsc_pkg::NUM_W'(pp_q[c][3]) << pwsc_pkg::PROD_W)
             + ((pwsc_pkg::NUM_W'(pp_q[c][1]) + pwsc_pkg::NUM_W'(pp_q[c][2]))
                << pwsc_pkg::HALF_W)
             + pwsc_pkg::NUM_W'(pp_q[c][0]);
    end
  end

  // Stage C: top dividend bits start the remainder; if they already reach
  // the divisor the quotient cannot fit and saturates.
  always_comb begin
    logic [pwsc_pkg::DM_W-1:0] r0x, r0y;
    r0x = pwsc_pkg::DM_W'(n_q[0][pwsc_pkg::NUM_W-1:pwsc_pkg::Q_W]);
    r0y = pwsc_pkg::DM_W'(n_q[1][pwsc_pkg::NUM_W-1:pwsc_pkg::Q_W]);
    div_d.x.rem = r0x;
    div_d.x.num = n_q[0][pwsc_pkg::Q_W-1:0];
    div_d.x.ovf = (r0x >= pb_q.dm);
    div_d.x.neg = pb_q.neg_x;
    div_d.y.rem = r0y;
    div_d.y.num = n_q[1][pwsc_pkg::Q_W-1:0];
    div_d.y.ovf = (r0y >= pb_q.dm);
    div_d.y.neg = pb_q.neg_y;
    div_d.dm    = pb_q.dm;
    div_d.dz    = pb_q.dz;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_q  <= pp_d;
      pa_q  <= proj_i;
      n_q   <= n_d;
      pb_q  <= pa_q;
      div_q <= div_d;
    end
  end

  assign valid_o = vc_q;
  assign div_o   = div_q;

endmodule

/* hdl/pwsc_div_step.sv */
// ----------------------------------------------------------------------------
// pwsc_div_step
// One restoring division step for both coordinates, one quotient bit each.
// ----------------------------------------------------------------------------
module pwsc_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  pwsc_pkg::div_t div_i,
  output logic           valid_o,
  output pwsc_pkg::div_t div_o
);

  function automatic pwsc_pkg::div_chan_t step(pwsc_pkg::div_chan_t c,
                                               logic [pwsc_pkg::DM_W-1:0] dm);
    logic [pwsc_pkg::DM_W:0] t;
    logic                    ge;
    pwsc_pkg::div_chan_t     o;
    t     = {c.rem, c.num[pwsc_pkg::Q_W-1]};
    ge    = (t >= {1'b0, dm});
    o     = c;
    o.rem = ge ? pwsc_pkg::DM_W'(t - {1'b0, dm}) : pwsc_pkg::DM_W'(t);
    o.num = {c.num[pwsc_pkg::Q_W-2:0], ge};
    return o;
  endfunction

  pwsc_pkg::div_t div_d, div_q;
  logic           v_q;

  always_comb begin
    div_d   = div_i;
    div_d.x = step(div_i.x, div_i.dm);
    div_d.y = step(div_i.y, div_i.dm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = v_q;
  assign div_o   = div_q;

endmodule

/* hdl/pwsc_round.sv */
// ----------------------------------------------------------------------------
// pwsc_round
// Saturates and signs the quotient, adds the principal point, rounds to a
// pixel and checks it against the source size, in four stages.
// ----------------------------------------------------------------------------
module pwsc_round #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  pwsc_pkg::div_t                div_i,
  input  logic [pwsc_pkg::PPV_W-1:0]    pp_i,
  input  logic [pwsc_pkg::SIZE_W-1:0]   size_i,
  output logic                          valid_o,
  output pwsc_pkg::res_t                res_o
);

  logic signed [pwsc_pkg::S_W-1:0] qs_d [2], qs_q [2];
  logic signed [pwsc_pkg::S_W-1:0] s_d  [2], s_q  [2];
  logic [pwsc_pkg::S_W-1:0]        mag_d[2], mag_q[2];
  logic                            sn_d [2], sn_q [2];
  logic [pwsc_pkg::PP_W-1:0]       ppc  [2];
  logic [pwsc_pkg::PIX_W-1:0]      lim  [2];
  pwsc_pkg::div_chan_t             ch   [2];
  logic                            dz1_q, dz2_q, dz3_q;
  pwsc_pkg::res_t                  res_d, res_q;
  logic                            v1_q, v2_q, v3_q, v4_q;

  assign ch[0]  = div_i.x;
  assign ch[1]  = div_i.y;
  assign ppc[0] = pp_i[pwsc_pkg::PP_W-1:0];
  assign ppc[1] = pp_i[pwsc_pkg::PPV_W-1:pwsc_pkg::PP_W];
  assign lim[0] = size_i[pwsc_pkg::PIX_W-1:0];
  assign lim[1] = size_i[pwsc_pkg::SIZE_W-1:pwsc_pkg::PIX_W];

  always_comb begin
    logic [pwsc_pkg::Q_W-1:0] q;
    for (int c = 0; c < 2; c++) begin
      q = (ch[c].ovf || ch[c].num > pwsc_pkg::Q_LIMIT) ? pwsc_pkg::Q_LIMIT : ch[c].num;
      qs_d[c] = ch[c].neg ? -$signed(pwsc_pkg::S_W'(q)) : $signed(pwsc_pkg::S_W'(q));
      s_d[c]  = qs_q[c] + $signed(pwsc_pkg::S_W'(ppc[c]));
      sn_d[c] = s_q[c][pwsc_pkg::S_W-1];
      mag_d[c] = sn_d[c] ? -s_q[c] : s_q[c];
    end
  end

  always_comb begin
    logic [pwsc_pkg::S_W-1:0] m [2];
    logic                     ok [2];
    for (int c = 0; c < 2; c++) begin
      m[c]  = (mag_q[c] + (pwsc_pkg::S_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      // A negative value that rounds to zero is pixel zero.
      ok[c] = (!sn_q[c] || m[c] == '0)
            && (m[c][pwsc_pkg::S_W-1:pwsc_pkg::PIX_W] == '0)
            && (m[c][pwsc_pkg::PIX_W-1:0] < lim[c]);
    end
    res_d.in_range = !dz3_q && ok[0] && ok[1];
    res_d.src_x    = res_d.in_range ? m[0][pwsc_pkg::PIX_W-1:0] : '0;
    res_d.src_y    = res_d.in_range ? m[1][pwsc_pkg::PIX_W-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qs_q  <= qs_d;
      dz1_q <= div_i.dz;
      s_q   <= s_d;
      dz2_q <= dz1_q;
      sn_q  <= sn_d;
      mag_q <= mag_d;
      dz3_q <= dz2_q;
      res_q <= res_d;
    end
  end

  assign valid_o = v4_q;
  assign res_o   = res_q;

endmodule

/* hdl/perspective_warp_source_coords_top.sv */
// ----------------------------------------------------------------------------
// perspective_warp_source_coords_top
// Maps a destination pixel to its nearest source pixel through a planar
// perspective projection.
// ----------------------------------------------------------------------------
// Usage:
//   Destination pixels enter on the input channel (in_valid_i / in_ready_o,
//   dest_x_i, dest_y_i), one transaction per clock when the receiver keeps up.
//   Each produces one transaction on the output channel (out_valid_o /
//   out_ready_i) carrying src_x_o, src_y_o and in_range_o, in input order.
//   Throughput is one transaction per cycle while the receiver keeps up.
//   The depth is set by the 63-stage restoring divider that forms h*r/d
//   one quotient bit per stage, plus three plane stages, three multiply
//   stages, four rounding stages and the output register.
//   The configuration port (cfg_we_i, cfg_addr_i, cfg_wdata_i) writes one
//   register per cycle and must only be used while the pipeline is empty.
//   Reset clears all valid bits and loads the register defaults (camera
//   height 1.0, everything else zero). When the receiver stalls, the last
//   result waits in the output register and one more lands in a skid
//   register; in_ready_o then drops and the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module perspective_warp_source_coords_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pwsc_pkg::CFG_AW-1:0]     cfg_addr_i,
  input  logic [pwsc_pkg::CFG_DW-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [pwsc_pkg::DEST_W-1:0]     dest_x_i,
  input  logic [pwsc_pkg::DEST_W-1:0]     dest_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [pwsc_pkg::PIX_W-1:0]      src_x_o,
  output logic [pwsc_pkg::PIX_W-1:0]      src_y_o,
  output logic                            in_range_o
);

  localparam logic [pwsc_pkg::H_W-1:0] HeightReset = pwsc_pkg::H_W'(1) << FRAC_BITS;

  // Configuration registers.
  logic [pwsc_pkg::VEC_W-1:0]         unit_x_q, unit_y_q;
  logic signed [pwsc_pkg::ORG_W-1:0]  origin_x_q, origin_y_q, origin_z_q;
  logic [pwsc_pkg::H_W-1:0]           height_q;
  logic [pwsc_pkg::PPV_W-1:0]         pp_q;
  logic [pwsc_pkg::SIZE_W-1:0]        size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_x_q   <= '0;
      unit_y_q   <= '0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      height_q   <= HeightReset;
      pp_q       <= '0;
      size_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pwsc_pkg::REG_UNIT_X:   unit_x_q   <= cfg_wdata_i;
        pwsc_pkg::REG_UNIT_Y:   unit_y_q   <= cfg_wdata_i;
        pwsc_pkg::REG_ORIGIN_X: origin_x_q <= cfg_wdata_i[pwsc_pkg::ORG_W-1:0];
        pwsc_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_wdata_i[pwsc_pkg::ORG_W-1:0];
        pwsc_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_wdata_i[pwsc_pkg::ORG_W-1:0];
        pwsc_pkg::REG_HEIGHT:   height_q   <= cfg_wdata_i[pwsc_pkg::H_W-1:0];
        pwsc_pkg::REG_PP:       pp_q       <= cfg_wdata_i[pwsc_pkg::PPV_W-1:0];
        pwsc_pkg::REG_SIZE:     size_q     <= cfg_wdata_i[pwsc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register is full.
  logic            en;
  logic            skid_v_q, out_v_q;
  pwsc_pkg::res_t  skid_q, out_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  logic             plane_v;
  pwsc_pkg::proj_t  plane_proj;

  pwsc_plane #(
    .FRAC_BITS (FRAC_BITS)
  ) u_plane (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .dest_x_i   (dest_x_i),
    .dest_y_i   (dest_y_i),
    .unit_x_i   (unit_x_q),
    .unit_y_i   (unit_y_q),
    .origin_x_i (origin_x_q),
    .origin_y_i (origin_y_q),
    .origin_z_i (origin_z_q),
    .height_i   (height_q),
    .valid_o    (plane_v),
    .proj_o     (plane_proj)
  );

  logic            div_v [pwsc_pkg::Q_W+1];
  pwsc_pkg::div_t  div_s [pwsc_pkg::Q_W+1];

  pwsc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (plane_v),
    .proj_i   (plane_proj),
    .height_i (height_q),
    .valid_o  (div_v[0]),
    .div_o    (div_s[0])
  );

  // One stage per quotient bit, most significant first.
  for (genvar i = 0; i < pwsc_pkg::Q_W; i++) begin : g_div
    pwsc_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_v[i]),
      .div_i   (div_s[i]),
      .valid_o (div_v[i+1]),
      .div_o   (div_s[i+1])
    );
  end

  logic            last_v;
  pwsc_pkg::res_t  last_res;

  pwsc_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_v[pwsc_pkg::Q_W]),
    .div_i   (div_s[pwsc_pkg::Q_W]),
    .pp_i    (pp_q),
    .size_i  (size_q),
    .valid_o (last_v),
    .res_o   (last_res)
  );

  // Output register with a skid register behind it. While the skid holds a
  // transaction the pipeline is frozen, so the last stage never overruns.
  logic take;
  assign take = out_ready_i || !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (take) begin
      out_v_q <= last_v;
    end else if (last_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (take) begin
      out_q <= last_res;
    end else if (last_v) begin
      skid_q <= last_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign src_x_o     = out_q.src_x;
  assign src_y_o     = out_q.src_y;
  assign in_range_o  = out_q.in_range;

endmodule

/* hdl/pwsc_checker.sv */
// ----------------------------------------------------------------------------
// pwsc_checker
// Port-level checks of the source coordinate generator, bound to the top.
// ----------------------------------------------------------------------------
module pwsc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_we_i,
  input logic [pwsc_pkg::CFG_AW-1:0]  cfg_addr_i,
  input logic [pwsc_pkg::CFG_DW-1:0]  cfg_wdata_i,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic [pwsc_pkg::DEST_W-1:0]  dest_x_i,
  input logic [pwsc_pkg::DEST_W-1:0]  dest_y_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [pwsc_pkg::PIX_W-1:0]   src_x_o,
  input logic [pwsc_pkg::PIX_W-1:0]   src_y_o,
  input logic                         in_range_o
);

  // Shadow of the source size register, seen through the write port.
  logic [pwsc_pkg::SIZE_W-1:0] size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i && cfg_addr_i == pwsc_pkg::REG_SIZE) begin
      size_q <= cfg_wdata_i[pwsc_pkg::SIZE_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(src_x_o)
      && $stable(src_y_o) && $stable(in_range_o))
    else $error("output transaction changed while stalled");

  a_zero_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> src_x_o == '0 && src_y_o == '0)
    else $error("coordinates not zero for an out-of-range pixel");

  a_inside_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> src_x_o < size_q[pwsc_pkg::PIX_W-1:0]
      && src_y_o < size_q[pwsc_pkg::SIZE_W-1:pwsc_pkg::PIX_W])
    else $error("in-range pixel lies outside the source size");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o && in_ready_o)
    else $error("output valid or input stalled during reset");

endmodule

bind perspective_warp_source_coords_top pwsc_checker u_pwsc_checker (.*);
